@@ rtl/cxb_pkg.sv @@
// shared types, codes and defaults for the level-crossing sensor controller
`timescale 1ns / 1ps
`default_nettype none
package cxb_pkg;

   localparam int SENSOR_COUNT_DEF = 4;
   localparam int SENSOR_IDX_W     = 3;   // holds any lane number from 0 to 7
   localparam int FIELD_SENSORS    = 4;   // sensors that have a level bit and an indicator bit

   localparam int REQ_W      = 2;
   localparam int TIME_W     = 8;
   localparam int ROLE_W     = 2;
   localparam int DUTY_W     = 10;
   localparam int COUNT_W    = 8;
   localparam int PULSE_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // request codes
   localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEFORE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AFTER    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE    = 3'd4;

   localparam logic [TIME_W-1:0] DEBOUNCE_RST = 8'd4;
   localparam logic [ROLE_W-1:0] BEFORE_RST   = 2'd0;
   localparam logic [ROLE_W-1:0] AFTER_RST    = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_ACTIVE   = 2'd1,
      PH_DEBOUNCE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [TIME_W-1:0] debounce_ticks;
      logic [ROLE_W-1:0] before_idx;
      logic [ROLE_W-1:0] after_idx;
      logic [DUTY_W-1:0] open_duty;
      logic [DUTY_W-1:0] close_duty;
   } cfg_type;

   typedef struct packed {
      logic changed;
      logic rise_idle;
      logic released;
      logic busy_next;
   } lane_evt_type;

endpackage
`default_nettype wire

@@ rtl/cxb_req_if.sv @@
// sample / tick / start-up request channel
`timescale 1ns / 1ps
`default_nettype none
interface cxb_req_if import cxb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [3:0]        sensor_levels;

   modport source (output valid, req_type, sensor_levels, input ready);
   modport sink   (input valid, req_type, sensor_levels, output ready);
endinterface
`default_nettype wire

@@ rtl/cxb_rsp_if.sv @@
// result channel
`timescale 1ns / 1ps
`default_nettype none
interface cxb_rsp_if import cxb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [3:0]         indicators;
   logic [DUTY_W-1:0]  barrier_duty;
   logic [COUNT_W-1:0] trains_inside;
   logic [PULSE_W-1:0] pulse_count;

   modport source (output valid, indicators, barrier_duty, trains_inside, pulse_count,
                   input ready);
   modport sink   (input valid, indicators, barrier_duty, trains_inside, pulse_count,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/cxb_csr_if.sv @@
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface cxb_csr_if import cxb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/crossing_sensor_debounce_barrier.sv @@
// Level-crossing barrier controller over a row of debounced track sensors.
// req_ch carries one beat per event: a sensor sample with all levels, a
// timer tick, or the start-up safe-time notice. Each request beat produces
// exactly one rsp_ch beat with the indicator lines, the servo duty now
// applied, the train count and the number of interrupt pulses raised.
// csr_ch writes the debounce time, the before/after sensor selection and
// the open/close duty values; it is always ready and should be used only
// while no request is in flight.
// A request beat lands in an input register; when that register moves on,
// the sensor lanes and the train counter update in one pass and the result
// is loaded into the output register. One request per cycle is sustained:
// the input register moves on whenever the output register is empty or
// being drained. When rsp_ch stalls, the output register holds its beat
// and one further request waits in the input register before req_ch.ready
// drops.
// Reset clears the pipeline, time, levels, sensor phases, train count and
// closes the barrier; configuration returns to its defaults.
`timescale 1ns / 1ps
`default_nettype none
module crossing_sensor_debounce_barrier import cxb_pkg::*; #(
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   cxb_req_if.sink   req_ch,
   cxb_rsp_if.source rsp_ch,
   cxb_csr_if.sink   csr_ch
);
   localparam int PSUM_W = $clog2(SENSOR_COUNT + 1) + 1;

   cfg_type cfg;

   // input register
   logic              in_valid_ff;
   logic [REQ_W-1:0]  in_type_ff;
   logic [3:0]        in_levels_ff;
   logic              advance;

   // shared state
   logic [TIME_W-1:0]  tick_ff;
   logic [TIME_W-1:0]  tick_in;
   logic [TIME_W-1:0]  tick_next;
   logic [COUNT_W-1:0] trains_ff;
   logic [COUNT_W-1:0] trains_in;
   logic               open_ff;
   logic               open_in;
   logic               early_ff;
   logic               early_in;

   // output register
   logic               rsp_valid_ff;
   logic [3:0]         ind_ff;
   logic [3:0]         ind_in;
   logic [DUTY_W-1:0]  duty_ff;
   logic [PULSE_W-1:0] pulse_ff;
   logic [PULSE_W-1:0] pulse_in;

   lane_evt_type            evt [SENSOR_COUNT];
   logic [SENSOR_COUNT-1:0] is_before;
   logic [SENSOR_COUNT-1:0] is_after;
   logic [SENSOR_COUNT-1:0] rise_vec;
   logic [SENSOR_COUNT-1:0] rel_vec;
   logic [SENSOR_COUNT-1:0] chg_vec;
   logic                    count_in_hit;
   logic                    count_out_hit;
   logic [COUNT_W-1:0]      trains_dec;
   logic [PSUM_W-1:0]       psum;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign tick_next    = tick_ff + 8'd1;

   cxb_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
      logic level;

      if (i < FIELD_SENSORS) begin : g_pin
         assign level     = in_levels_ff[i];
         assign ind_in[i] = evt[i].busy_next;
      end else begin : g_nopin
         assign level = 1'b0;
      end

      assign is_before[i] = ({1'b0, cfg.before_idx} == SENSOR_IDX_W'(i));
      assign is_after[i]  = ({1'b0, cfg.after_idx} == SENSOR_IDX_W'(i));
      assign rise_vec[i]  = evt[i].rise_idle;
      assign rel_vec[i]   = evt[i].released;
      assign chg_vec[i]   = evt[i].changed;

      cxb_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .fire           (advance),
         .req_type       (in_type_ff),
         .level          (level),
         .tick_now       (tick_ff),
         .tick_next      (tick_next),
         .debounce_ticks (cfg.debounce_ticks),
         .evt            (evt[i])
      );
   end

   // indicator bits for sensors the row does not have
   for (genvar j = SENSOR_COUNT; j < FIELD_SENSORS; j++) begin : g_noind
      assign ind_in[j] = 1'b0;
   end

   assign count_in_hit  = |(rise_vec & is_before);
   assign count_out_hit = |(rel_vec & is_after);
   assign trains_dec    = (trains_ff != '0) ? trains_ff - 8'd1 : trains_ff;

   always_comb begin
      psum = '0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
         psum = psum + PSUM_W'(rise_vec[k]) + PSUM_W'(rel_vec[k]);
      end
      pulse_in = (psum > PSUM_W'(7)) ? 3'd7 : psum[PULSE_W-1:0];
   end

   always_comb begin
      tick_in   = tick_ff;
      trains_in = trains_ff;
      open_in   = open_ff;
      early_in  = early_ff || (|(chg_vec & (is_before | is_after)));
      case (in_type_ff)
         REQ_SAMPLE: begin
            if (count_in_hit) begin
               open_in = 1'b0;
               if (trains_ff != '1) begin
                  trains_in = trains_ff + 8'd1;
               end
            end
         end
         REQ_TICK: begin
            tick_in = tick_next;
            if (count_out_hit) begin
               trains_in = trains_dec;
               if (trains_dec == '0) begin
                  open_in = 1'b1;
               end
            end
         end
         REQ_START: begin
            if (!early_ff) begin
               open_in = 1'b1;
            end
         end
         default: begin
            tick_in = tick_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         trains_ff    <= '0;
         open_ff      <= 1'b0;
         early_ff     <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            tick_ff      <= tick_in;
            trains_ff    <= trains_in;
            open_ff      <= open_in;
            early_ff     <= early_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_type_ff   <= req_ch.req_type;
         in_levels_ff <= req_ch.sensor_levels;
      end
      if (advance) begin
         ind_ff   <= ind_in;
         duty_ff  <= open_in ? cfg.open_duty : cfg.close_duty;
         pulse_ff <= pulse_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.indicators    = ind_ff;
   assign rsp_ch.barrier_duty  = duty_ff;
   assign rsp_ch.trains_inside = trains_ff;
   assign rsp_ch.pulse_count   = pulse_ff;
endmodule
`default_nettype wire

@@ rtl/cxb_csr.sv @@
// configuration registers
`timescale 1ns / 1ps
`default_nettype none
module cxb_csr import cxb_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   cxb_csr_if.sink    csr_ch,
   output cfg_type    cfg
);
   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks = csr_ch.data[TIME_W-1:0];
            CSR_BEFORE:   cfg_in.before_idx     = csr_ch.data[ROLE_W-1:0];
            CSR_AFTER:    cfg_in.after_idx      = csr_ch.data[ROLE_W-1:0];
            CSR_OPEN:     cfg_in.open_duty      = csr_ch.data[DUTY_W-1:0];
            CSR_CLOSE:    cfg_in.close_duty     = csr_ch.data[DUTY_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RST;
         cfg_ff.before_idx     <= BEFORE_RST;
         cfg_ff.after_idx      <= AFTER_RST;
         cfg_ff.open_duty      <= '0;
         cfg_ff.close_duty     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/cxb_lane.sv @@
// per-sensor edge detect and debounce state
`timescale 1ns / 1ps
`default_nettype none
module cxb_lane import cxb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [REQ_W-1:0]  req_type,
   input  wire logic              level,
   input  wire logic [TIME_W-1:0] tick_now,
   input  wire logic [TIME_W-1:0] tick_next,
   input  wire logic [TIME_W-1:0] debounce_ticks,
   output lane_evt_type           evt
);
   logic              last_ff;
   logic              last_in;
   phase_type         phase_ff;
   phase_type         phase_in;
   logic [TIME_W-1:0] stamp_ff;
   logic [TIME_W-1:0] stamp_in;
   logic [TIME_W-1:0] elapsed;

   // modulo-256 time since the falling edge
   assign elapsed = tick_next - stamp_ff;

   always_comb begin
      last_in  = last_ff;
      phase_in = phase_ff;
      stamp_in = stamp_ff;
      evt      = '0;
      case (req_type)
         REQ_SAMPLE: begin
            if (level != last_ff) begin
               evt.changed = 1'b1;
               last_in     = level;
               if (level) begin
                  evt.rise_idle = (phase_ff == PH_IDLE);
                  phase_in      = PH_ACTIVE;
               end else begin
                  stamp_in = tick_now;
                  phase_in = PH_DEBOUNCE;
               end
            end
         end
         REQ_TICK: begin
            if (phase_ff == PH_DEBOUNCE && elapsed >= debounce_ticks) begin
               evt.released = 1'b1;
               phase_in     = PH_IDLE;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      evt.busy_next = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= 1'b0;
         phase_ff <= PH_IDLE;
      end else if (fire) begin
         last_ff  <= last_in;
         phase_ff <= phase_in;
      end
   end

   // stamp is only read after a falling edge has written it
   always_ff @(posedge clock) begin
      if (fire) begin
         stamp_ff <= stamp_in;
      end
   end
endmodule
`default_nettype wire

@@ dv/crossing_sensor_debounce_barrier_tb.sv @@
// self-checking testbench for the level-crossing sensor controller
`timescale 1ns / 1ps
module crossing_sensor_debounce_barrier_tb;
   import cxb_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 1000;
   localparam int HOLD_CYCLES = 64;

   typedef struct packed {
      logic [3:0]         indicators;
      logic [DUTY_W-1:0]  barrier_duty;
      logic [COUNT_W-1:0] trains_inside;
      logic [PULSE_W-1:0] pulse_count;
   } crossing_view_type;

   // mirror of the crossing state, predicts the view after each request beat
   class crossing_tracker;
      cfg_type            cfg;
      logic [TIME_W-1:0]  now_ticks;
      logic [3:0]         levels;
      phase_type          phase [FIELD_SENSORS];
      logic [TIME_W-1:0]  stamp [FIELD_SENSORS];
      logic [COUNT_W-1:0] trains;
      logic               barrier_up;
      logic               role_moved;
      crossing_view_type  expected_views [$];
      int                 errors;

      function new();
         cfg.debounce_ticks = DEBOUNCE_RST;
         cfg.before_idx     = BEFORE_RST;
         cfg.after_idx      = AFTER_RST;
         cfg.open_duty      = '0;
         cfg.close_duty     = '0;
         now_ticks  = '0;
         levels     = '0;
         trains     = '0;
         barrier_up = 1'b0;
         role_moved = 1'b0;
         errors     = 0;
         for (int i = 0; i < FIELD_SENSORS; i++) begin
            phase[i] = PH_IDLE;
            stamp[i] = '0;
         end
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_DEBOUNCE: cfg.debounce_ticks = val[TIME_W-1:0];
            CSR_BEFORE:   cfg.before_idx     = val[ROLE_W-1:0];
            CSR_AFTER:    cfg.after_idx      = val[ROLE_W-1:0];
            CSR_OPEN:     cfg.open_duty      = val[DUTY_W-1:0];
            CSR_CLOSE:    cfg.close_duty     = val[DUTY_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(input logic [REQ_W-1:0] kind, input logic [3:0] lv);
         int                pulses;
         crossing_view_type view;
         pulses = 0;
         case (kind)
            REQ_SAMPLE: begin
               for (int i = 0; i < FIELD_SENSORS; i++) begin
                  if (lv[i] != levels[i]) begin
                     levels[i] = lv[i];
                     if (i == cfg.before_idx || i == cfg.after_idx)
                        role_moved = 1'b1;
                     if (lv[i]) begin
                        if (phase[i] == PH_IDLE) begin
                           if (i == cfg.before_idx) begin
                              barrier_up = 1'b0;
                              if (trains != '1)
                                 trains++;
                           end
                           pulses++;
                        end
                        phase[i] = PH_ACTIVE;
                     end else begin
                        stamp[i] = now_ticks;
                        phase[i] = PH_DEBOUNCE;
                     end
                  end
               end
            end
            REQ_TICK: begin
               now_ticks++;
               for (int i = 0; i < FIELD_SENSORS; i++) begin
                  // elapsed time wraps at 8 bits
                  if (phase[i] == PH_DEBOUNCE &&
                      TIME_W'(now_ticks - stamp[i]) >= cfg.debounce_ticks) begin
                     if (i == cfg.after_idx) begin
                        if (trains != '0)
                           trains--;
                        if (trains == '0)
                           barrier_up = 1'b1;
                     end
                     phase[i] = PH_IDLE;
                     pulses++;
                  end
               end
            end
            REQ_START: begin
               if (!role_moved)
                  barrier_up = 1'b1;
            end
            default: ;
         endcase
         for (int i = 0; i < FIELD_SENSORS; i++)
            view.indicators[i] = (phase[i] != PH_IDLE);
         view.barrier_duty  = barrier_up ? cfg.open_duty : cfg.close_duty;
         view.trains_inside = trains;
         if (pulses > 7)
            pulses = 7;
         view.pulse_count = PULSE_W'(pulses);
         expected_views.push_back(view);
      endfunction

      function void check_view(input crossing_view_type got);
         crossing_view_type want;
         if (expected_views.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            errors++;
            return;
         end
         want = expected_views.pop_front();
         if (got.indicators !== want.indicators) begin
            $error("indicators: expected %h, got %h", want.indicators, got.indicators);
            errors++;
         end
         if (got.barrier_duty !== want.barrier_duty) begin
            $error("barrier_duty: expected %0d, got %0d", want.barrier_duty, got.barrier_duty);
            errors++;
         end
         if (got.trains_inside !== want.trains_inside) begin
            $error("trains_inside: expected %0d, got %0d", want.trains_inside,
                   got.trains_inside);
            errors++;
         end
         if (got.pulse_count !== want.pulse_count) begin
            $error("pulse_count: expected %0d, got %0d", want.pulse_count, got.pulse_count);
            errors++;
         end
      endfunction

      function int pending();
         return expected_views.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   cxb_req_if req_ch ();
   cxb_rsp_if rsp_ch ();
   cxb_csr_if csr_ch ();

   crossing_sensor_debounce_barrier dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   crossing_tracker tracker = new();

   int         send_idle_pct;
   int         rsp_idle_pct;
   int         items_sent;
   bit         hold_request;
   logic [3:0] cur_levels;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_view({rsp_ch.indicators, rsp_ch.barrier_duty, rsp_ch.trains_inside,
                             rsp_ch.pulse_count});
   end

   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && hold_left == 0) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // entered and left just after a falling edge
   task automatic send_item(input logic [REQ_W-1:0] kind, input logic [3:0] lv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= kind;
      req_ch.sensor_levels <= lv;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(kind, lv);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_sample(input logic [3:0] lv);
      cur_levels = lv;
      send_item(REQ_SAMPLE, lv);
   endtask

   // levels ride along on ticks but must be ignored
   task automatic send_ticks(input int n);
      repeat (n) send_item(REQ_TICK, 4'($urandom_range(15)));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
   endtask

   task automatic configure(input logic [TIME_W-1:0] dbt, input logic [ROLE_W-1:0] bi,
                            input logic [ROLE_W-1:0] ai, input logic [DUTY_W-1:0] od,
                            input logic [DUTY_W-1:0] cd);
      logic [CSR_IDX_W-1:0]  regs [5];
      logic [CSR_DATA_W-1:0] vals [5];
      regs = '{CSR_DEBOUNCE, CSR_BEFORE, CSR_AFTER, CSR_OPEN, CSR_CLOSE};
      vals = '{CSR_DATA_W'(dbt), CSR_DATA_W'(bi), CSR_DATA_W'(ai), CSR_DATA_W'(od),
               CSR_DATA_W'(cd)};
      for (int k = 0; k < 5; k++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= regs[k];
         csr_ch.data  <= vals[k];
         do @(posedge clock); while (!csr_ch.ready);
         tracker.write_reg(regs[k], vals[k]);
         @(negedge clock);
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_pace(input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
   endtask

   task automatic run_traffic(input int budget);
      int                stop_at;
      int                dwell;
      int                pick;
      logic [ROLE_W-1:0] s;
      logic [3:0]        roles;
      logic [3:0]        lv;
      stop_at = items_sent + budget;
      roles = '0;
      roles[tracker.cfg.before_idx] = 1'b1;
      roles[tracker.cfg.after_idx]  = 1'b1;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         // long enough to release when the time is short, a long time runs out in a tick burst
         if (tracker.cfg.debounce_ticks <= 12)
            dwell = tracker.cfg.debounce_ticks + $urandom_range(1);
         else
            dwell = $urandom_range(12);
         if (pick < 55) begin
            // train hits the before sensor, later clears the after sensor
            for (int leg = 0; leg < 2; leg++) begin
               s = (leg == 0) ? tracker.cfg.before_idx : tracker.cfg.after_idx;
               lv = (cur_levels & roles) | (4'($urandom_range(15)) & ~roles);
               lv[s] = 1'b1;
               send_sample(lv);
               send_ticks($urandom_range(2));
               lv = (cur_levels & roles) | (4'($urandom_range(15)) & ~roles);
               lv[s] = 1'b0;
               send_sample(lv);
               send_ticks(dwell);
            end
         end else if (pick < 75) begin
            // contact bounce: drop and come back after at most two ticks
            s = ROLE_W'($urandom_range(3));
            lv = cur_levels;
            lv[s] = 1'b1;
            send_sample(lv);
            lv[s] = 1'b0;
            send_sample(lv);
            send_ticks($urandom_range(2));
            lv[s] = 1'b1;
            send_sample(lv);
            lv[s] = 1'b0;
            send_sample(lv);
            send_ticks(dwell);
         end else begin
            case ($urandom_range(4))
               0: send_ticks(1);
               1: send_item(REQ_START, 4'($urandom_range(15)));
               2: send_item(REQ_UNUSED, 4'($urandom_range(15)));
               default: send_sample(4'($urandom_range(15)));
            endcase
         end
      end
   endtask

   initial begin
      logic [3:0] lv;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.req_type      = REQ_SAMPLE;
      req_ch.sensor_levels = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_DEBOUNCE;
      csr_ch.data          = '0;
      hold_request         = 1'b0;
      items_sent           = 0;
      cur_levels           = '0;
      set_pace(29, 75);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default roles, open duty at its top
      configure(DEBOUNCE_RST, BEFORE_RST, AFTER_RST, '1, '0);
      send_item(REQ_UNUSED, 4'hf);
      send_item(REQ_TICK, 4'hf);
      send_item(REQ_START, 4'h0);       // nothing moved yet, barrier opens
      send_sample(4'b0001);             // train in, barrier closes
      send_sample(4'b1111);
      send_sample(4'b1110);
      send_sample(4'b1111);             // bounce back to active, no pulse
      send_sample(4'b0000);
      send_item(REQ_START, 4'hf);       // too late, a role sensor moved
      send_ticks(4);                    // all four release together
      send_item(REQ_UNUSED, 4'h0);
      drain();

      // one sensor in both roles, zero debounce, close duty at its top
      configure('0, 2'd2, 2'd2, '0, '1);
      send_sample(4'b0100);
      send_sample(4'b0000);
      send_ticks(2);
      send_sample(4'b0100);
      run_traffic(160);
      drain();

      set_pace(75, 29);
      configure('1, 2'd3, 2'd0, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      run_traffic(120);
      // every debouncing sensor runs out across the time wrap
      send_ticks(256);
      drain();

      // receiver stalls for a long stretch while requests keep coming
      set_pace(0, 0);
      configure(8'($urandom_range(1, 10)), ROLE_W'($urandom_range(3)),
                ROLE_W'($urandom_range(3)), 10'($urandom_range(1023)),
                10'($urandom_range(1023)));
      hold_request = 1'b1;
      run_traffic(280);
      drain();

      // push the train count into saturation, then let some trains out
      configure('0, 2'd1, 2'd2, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      repeat (258) begin
         lv = 4'($urandom_range(15));
         lv[tracker.cfg.before_idx] = 1'b1;
         lv[tracker.cfg.after_idx]  = 1'b0;
         send_sample(lv);
         lv[tracker.cfg.before_idx] = 1'b0;
         send_sample(lv);
         send_ticks(1);
      end
      run_traffic(40);
      drain();

      repeat (8) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
